### hw/rtl/tvh_pkg.sv
// ----------------------------------------------------------------------------
// tvh_pkg
// Shared types and constants for the typed value hash block.
// ----------------------------------------------------------------------------
`default_nettype none

package tvh_pkg;

   // splitmix64 finalizer multipliers
   localparam logic [63:0] MIX_MUL_A       = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL_B       = 64'h94d049bb133111eb;

   localparam logic [63:0] BOOL_TRUE_HASH  = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] BOOL_FALSE_HASH = 64'hd6e8feb86659fd93;
   localparam logic [63:0] NEG_ZERO_BITS   = 64'h8000000000000000;

   // FNV-1a 64: prime = 2^40 + 0x1b3
   localparam logic [63:0] FNV_BASIS       = 64'hcbf29ce484222325;
   localparam logic [8:0]  FNV_PRIME_LO    = 9'h1b3;
   localparam int          FNV_PRIME_SHIFT = 40;

   typedef enum logic [1:0] {
      MODE_INT    = 2'd0,
      MODE_DOUBLE = 2'd1,
      MODE_BOOL   = 2'd2,
      MODE_TEXT   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MIX_A,
      ST_MIX_B
   } state_type;

   typedef enum logic [1:0] {
      STEP_LL,
      STEP_HL,
      STEP_LH
   } mul_step_type;

   typedef struct packed {
      logic start;
      logic sel_b;   // 0: MIX_MUL_A, 1: MIX_MUL_B
   } mul_ctl_type;

endpackage

`default_nettype wire

### hw/rtl/tvh_mul_unit.sv
// ----------------------------------------------------------------------------
// tvh_mul_unit
// Low 64 bits of operand times a mix constant, built from one 32x32
// multiplier in three steps (lo*lo, hi*lo, lo*hi).
// ----------------------------------------------------------------------------
`default_nettype none

module tvh_mul_unit
   import tvh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_ctl_type ctl,
   input  logic [63:0] operand,
   output logic        done,
   output logic [63:0] product
);

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   mul_step_type step_ff, step_in;
   logic         sel_ff, sel_in;
   logic [63:0]  x_ff, x_in;
   logic [63:0]  acc_ff, acc_in;

   logic [63:0]  konst;
   logic [31:0]  op_a;
   logic [31:0]  op_b;
   logic [63:0]  part;

   assign konst = sel_ff ? MIX_MUL_B : MIX_MUL_A;
   assign op_a  = (step_ff == STEP_HL) ? x_ff[63:32] : x_ff[31:0];
   assign op_b  = (step_ff == STEP_LH) ? konst[63:32] : konst[31:0];
   assign part  = 64'(op_a) * 64'(op_b);

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      sel_in  = sel_ff;
      x_in    = x_ff;
      acc_in  = acc_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         busy_in = 1'b1;
         step_in = STEP_LL;
         sel_in  = ctl.sel_b;
         x_in    = operand;
      end else if (busy_ff) begin
         unique case (step_ff)
            STEP_LL: begin
               acc_in  = part;
               step_in = STEP_HL;
            end
            STEP_HL: begin
               // cross terms only reach the upper word
               acc_in  = {acc_ff[63:32] + part[31:0], acc_ff[31:0]};
               step_in = STEP_LH;
            end
            STEP_LH: begin
               acc_in  = {acc_ff[63:32] + part[31:0], acc_ff[31:0]};
               busy_in = 1'b0;
               done_in = 1'b1;
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= STEP_LL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff <= sel_in;
      x_ff   <= x_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

### hw/rtl/typed_value_hash_top.sv
// ----------------------------------------------------------------------------
// typed_value_hash_top
// Hashes integer, double, boolean and text column values to 64 bits.
// ----------------------------------------------------------------------------
// Integers and doubles go through the splitmix64 finalizer (double -0 hashes
// as +0); booleans give a fixed constant; text comes at most one byte per
// item (none when req_no_byte is set) and folds into a running FNV-1a 64
// hash that is returned on the item marked final_byte and then restarts
// from the offset basis. For an integer or double item the finalizer's two
// 64-bit multiplies run one after the other on a single shared 32x32
// multiplier, three partial products each. req_ready is low after accept
// until that result is loaded, and also while the result register holds an
// item that rsp_ready does not take, so no new item is accepted while a
// numeric one is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module typed_value_hash_top
   import tvh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [63:0] req_payload,
   input  logic        req_final_byte,
   input  logic        req_no_byte,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_hash_value
);

   state_type   state_ff, state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_hash_ff, rsp_hash_in;
   logic [63:0] text_acc_ff, text_acc_in;

   mode_type    mode;
   logic        accept;
   logic [63:0] num_bits;
   logic [63:0] pre_mix;
   logic [63:0] text_x;
   logic [63:0] text_fold;
   logic [63:0] text_sum;

   mul_ctl_type mul_ctl;
   logic [63:0] mul_operand;
   logic        mul_done;
   logic [63:0] mul_product;

   logic        rsp_load;
   logic [63:0] rsp_load_value;

   assign mode      = mode_type'(req_mode);
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign num_bits  = (mode == MODE_DOUBLE && req_payload == NEG_ZERO_BITS) ?
                      64'd0 : req_payload;
   assign pre_mix   = num_bits ^ (num_bits >> 30);

   // x * (2^40 + 0x1b3)
   assign text_x    = text_acc_ff ^ {56'd0, req_payload[7:0]};
   assign text_fold = (text_x << FNV_PRIME_SHIFT) + text_x * 64'(FNV_PRIME_LO);
   assign text_sum  = req_no_byte ? text_acc_ff : text_fold;

   tvh_mul_unit u_mul (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mul_ctl),
      .operand (mul_operand),
      .done    (mul_done),
      .product (mul_product)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (mode == MODE_INT || mode == MODE_DOUBLE)) begin
               state_in = ST_MIX_A;
            end
         end
         ST_MIX_A: begin
            if (mul_done) begin
               state_in = ST_MIX_B;
            end
         end
         ST_MIX_B: begin
            if (mul_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and datapath control
   always_comb begin
      mul_ctl        = '0;
      mul_operand    = pre_mix;
      rsp_load       = 1'b0;
      rsp_load_value = mul_product ^ (mul_product >> 31);
      text_acc_in    = text_acc_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (mode)
                  MODE_INT, MODE_DOUBLE: begin
                     mul_ctl.start = 1'b1;
                     mul_ctl.sel_b = 1'b0;
                  end
                  MODE_BOOL: begin
                     rsp_load       = 1'b1;
                     rsp_load_value = req_payload[0] ? BOOL_TRUE_HASH : BOOL_FALSE_HASH;
                  end
                  MODE_TEXT: begin
                     if (req_final_byte) begin
                        rsp_load       = 1'b1;
                        rsp_load_value = text_sum;
                        text_acc_in    = FNV_BASIS;
                     end else begin
                        text_acc_in    = text_sum;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MIX_A: begin
            mul_operand = mul_product ^ (mul_product >> 27);
            if (mul_done) begin
               mul_ctl.start = 1'b1;
               mul_ctl.sel_b = 1'b1;
            end
         end
         ST_MIX_B: begin
            rsp_load = mul_done;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   assign rsp_hash_in  = rsp_load ? rsp_load_value : rsp_hash_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         text_acc_ff  <= FNV_BASIS;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         text_acc_ff  <= text_acc_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hash_ff <= rsp_hash_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

endmodule

`default_nettype wire

### hw/rtl/tvh_checker.sv
// ----------------------------------------------------------------------------
// tvh_checker
// Port-level assertions for typed_value_hash_top, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module tvh_checker
   import tvh_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [1:0]  req_mode,
   input wire logic [63:0] req_payload,
   input wire logic        req_final_byte,
   input wire logic        req_no_byte,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [63:0] rsp_hash_value
);

   logic req_accept;
   assign req_accept = req_valid && req_ready;

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_hash_value)))
      else $error("result item changed while stalled");

   // an item is taken only when the result register can receive one
   a_ready_room: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!rsp_valid || rsp_ready))
      else $error("ready while result register is full");

   a_bool_hash: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_mode == MODE_BOOL) |=>
      (rsp_valid && rsp_hash_value ==
         ($past(req_payload[0]) ? BOOL_TRUE_HASH : BOOL_FALSE_HASH)))
      else $error("wrong boolean hash");

   a_numeric_busy: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_mode == MODE_INT || req_mode == MODE_DOUBLE)) |=>
      !req_ready)
      else $error("ready right after a numeric item");

   // a text item that is not final makes no result
   a_text_silent: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_mode == MODE_TEXT && !req_final_byte) |=>
      (rsp_valid == $past(rsp_valid && !rsp_ready)))
      else $error("result from a non-final text item");

endmodule

bind typed_value_hash_top tvh_checker u_tvh_checker (.*);

`default_nettype wire
